@@ rtl/xbmru_pkg.sv @@
package xbmru_pkg;

  localparam int unsigned WordBits  = 16;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned DimBits   = 14;
  localparam int unsigned ByteCntW  = 12;
  localparam int unsigned RunCntW   = 5;
  localparam int unsigned IndexBits = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 14;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth      = 3'd0,
    CfgHeight     = 3'd1,
    CfgX10        = 3'd2,
    CfgForeground = 3'd3,
    CfgBackground = 3'd4
  } cfg_idx_e;

  // Decoded pixel run of one raster word: pixel bits are a prefix of bits
  typedef struct packed {
    logic [WordBits-1:0] bits;
    logic [RunCntW-1:0]  cnt;
    logic                eoi;
  } run_t;

endpackage

@@ rtl/xbmru_decode.sv @@
module xbmru_decode import xbmru_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [WordBits-1:0] data_word_i,
  input  logic [DimBits-1:0]  width_i,
  input  logic [DimBits-1:0]  height_i,
  input  logic                x10_i,
  output run_t                run_o
);

  logic [DimBits-1:0]  col_q, col_d;
  logic [ByteCntW-1:0] bil_q, bil_d;
  logic [DimBits-1:0]  lines_q, lines_d;

  logic                active;
  logic                pad;
  logic [ByteCntW:0]   line_bytes;
  logic [ByteCntW:0]   bil_sum;
  logic                skip_hi;
  logic [DimBits-1:0]  rem_px;
  logic [RunCntW-1:0]  avail;
  logic [RunCntW-1:0]  n;
  logic                last_line;

  always_comb begin
    active     = lines_q < height_i;
    pad        = x10_i && (width_i[3:0] >= 4'd1) && (width_i[3:0] <= 4'd8);
    // ceil(width/8) plus the X10 padding byte
    line_bytes = {2'b00, width_i[DimBits-1:3]} + {{ByteCntW{1'b0}}, |width_i[2:0]}
               + {{ByteCntW{1'b0}}, pad};
    skip_hi    = pad && !(({1'b0, bil_q} + 13'd2) < line_bytes);
    rem_px     = (width_i > col_q) ? (width_i - col_q) : '0;

    if (!active)          avail = '0;
    else if (!x10_i)      avail = RunCntW'(ByteBits);
    else if (skip_hi)     avail = RunCntW'(ByteBits);
    else                  avail = RunCntW'(WordBits);

    n = ({{(DimBits-RunCntW){1'b0}}, avail} > rem_px) ? rem_px[RunCntW-1:0] : avail;

    last_line = ({1'b0, lines_q} + 15'd1) == {1'b0, height_i};

    run_o.bits = x10_i ? data_word_i : {8'h00, data_word_i[ByteBits-1:0]};
    run_o.cnt  = n;
    // last pixel of the image's last line lies inside this run
    run_o.eoi  = active && last_line && (rem_px != '0)
              && ({{(DimBits-RunCntW){1'b0}}, n} == rem_px);

    bil_sum = {1'b0, bil_q} + (x10_i ? 13'd2 : 13'd1);
    col_d   = col_q;
    bil_d   = bil_q;
    lines_d = lines_q;
    if (accept_i && active) begin
      if (bil_sum >= line_bytes) begin
        col_d   = '0;
        bil_d   = '0;
        lines_d = lines_q + 14'd1;
      end else begin
        col_d = col_q + {{(DimBits-RunCntW){1'b0}}, n};
        bil_d = bil_sum[ByteCntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      bil_q   <= '0;
      lines_q <= '0;
    end else begin
      col_q   <= col_d;
      bil_q   <= bil_d;
      lines_q <= lines_d;
    end
  end

endmodule

@@ rtl/xbmru_serial.sv @@
module xbmru_serial import xbmru_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  run_t                 run_i,
  output logic                 free_o,
  input  logic [IndexBits-1:0] fg_i,
  input  logic [IndexBits-1:0] bg_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IndexBits-1:0] pixel_index_o,
  output logic                 last_of_run_o,
  output logic                 end_of_image_o
);

  run_t run_q, run_d;
  logic out_valid_q, out_valid_d;
  logic [IndexBits-1:0] pix_q, pix_d;
  logic last_q, last_d, eoi_q, eoi_d;
  logic slot_ok, emit;

  always_comb begin
    slot_ok = !out_valid_q || !out_stall_i;
    emit    = (run_q.cnt != '0) && slot_ok;
    free_o  = (run_q.cnt == '0) || (emit && run_q.cnt == 5'd1);

    run_d = run_q;
    if (load_i) begin
      run_d = run_i;
    end else if (emit) begin
      run_d.bits = run_q.bits >> 1;
      run_d.cnt  = run_q.cnt - 5'd1;
    end

    out_valid_d = out_valid_q;
    pix_d       = pix_q;
    last_d      = last_q;
    eoi_d       = eoi_q;
    if (slot_ok) begin
      out_valid_d = emit;
      pix_d       = run_q.bits[0] ? fg_i : bg_i;
      last_d      = run_q.cnt == 5'd1;
      eoi_d       = run_q.eoi && (run_q.cnt == 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
      pix_q       <= '0;
      last_q      <= 1'b0;
      eoi_q       <= 1'b0;
    end else begin
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      pix_q       <= pix_d;
      last_q      <= last_d;
      eoi_q       <= eoi_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_index_o  = pix_q;
  assign last_of_run_o  = last_q;
  assign end_of_image_o = eoi_q;

endmodule

@@ rtl/xbm_raster_bit_unpacker.sv @@
// Pipeline: an accepted word lands in the run register at the accepting edge;
//   its pixels then pass through the output register, which holds on out_stall_i.
// Throughput: one pixel per cycle while out_stall_i is low; a word that yields
//   n pixels (16 for a full X10 word, 8 for an X11 byte) holds the input until
//   its last pixel leaves the run register; a word with no pixels never loads it.
// Reset (rst_ni, async low): counters and handshake state clear, config
//   registers take width 8, height 1, X11, foreground 0, background 1.
module xbm_raster_bit_unpacker import xbmru_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // raster word input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WordBits-1:0]  data_word_i,
  // pixel output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IndexBits-1:0] pixel_index_o,
  output logic                 last_of_run_o,
  output logic                 end_of_image_o
);

  logic [DimBits-1:0]   width_q, height_q;
  logic                 x10_q;
  logic [IndexBits-1:0] fg_q, bg_q;

  logic accept;
  logic run_free;
  run_t run;

  assign cfg_ready_o = 1'b1;

  // Config registers; writes to unlisted indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 14'd8;
      height_q <= 14'd1;
      x10_q    <= 1'b0;
      fg_q     <= 8'd0;
      bg_q     <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgWidth:      width_q  <= cfg_data_i;
        CfgHeight:     height_q <= cfg_data_i;
        CfgX10:        x10_q    <= cfg_data_i[0];
        CfgForeground: fg_q     <= cfg_data_i[IndexBits-1:0];
        CfgBackground: bg_q     <= cfg_data_i[IndexBits-1:0];
        default: ;
      endcase
    end
  end

  // A new word is taken whenever the run register empties this cycle, so
  // runs of consecutive words stream out without a gap.
  assign in_stall_o = !run_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Line/column bookkeeping and per-word pixel run decode
  xbmru_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_word_i (data_word_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .x10_i       (x10_q),
    .run_o       (run)
  );

  // Run register shifting one pixel per cycle, unless the output stalls, into the output register
  xbmru_serial u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept && (run.cnt != '0)),
    .run_i          (run),
    .free_o         (run_free),
    .fg_i           (fg_q),
    .bg_i           (bg_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_index_o  (pixel_index_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

@@ tb/sv/xbm_raster_bit_unpacker_tb.sv @@
module xbm_raster_bit_unpacker_tb;
  import xbmru_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int DimMax     = (1 << DimBits) - 1;

  // One expected output pixel
  typedef struct packed {
    logic [IndexBits-1:0] index;
    logic                 last;
    logic                 eoi;
  } pixel_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  cfg_idx_e             cfg_index_i    = CfgWidth;
  logic [CfgDataW-1:0]  cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [WordBits-1:0]  data_word_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [IndexBits-1:0] pixel_index_o;
  logic                 last_of_run_o;
  logic                 end_of_image_o;

  xbm_raster_bit_unpacker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_word_i    (data_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_index_o  (pixel_index_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

  // Register mirror, as last written into the block
  int                   img_width  = 8;
  int                   img_height = 1;
  bit                   x10_mode   = 1'b0;
  logic [IndexBits-1:0] fg_index   = 8'd0;
  logic [IndexBits-1:0] bg_index   = 8'd1;

  // Raster position; kept across register changes, as the block does
  int pix_col    = 0;
  int line_byte  = 0;
  int rows_done  = 0;

  logic [WordBits-1:0] words_to_send [$];
  pixel_t              pixels_due [$];
  int                  words_pending = 0;  // queued or on the bus, not yet taken
  int                  words_sent    = 0;  // words handed to the sender so far
  int                  fail_count    = 0;
  int                  cycle_count   = 0;
  bit                  calm          = 1'b0;  // no idling on either side
  int                  send_gap      = 0;
  int                  stall_left    = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Pixels of one raster word. X11 takes the low byte only; X10 takes the
  // low byte, then the high byte unless it is the padding byte at line end.
  function automatic void predict_pixels(logic [WordBits-1:0] word);
    pixel_t run [$];
    pixel_t p;
    int     line_len;
    int     nbytes;
    bit     pad;
    if (rows_done >= img_height) return;  // image finished: word dropped
    pad      = x10_mode && (img_width % 16) >= 1 && (img_width % 16) <= 8;
    line_len = ((img_width + 7) >> 3) + (pad ? 1 : 0);
    nbytes   = 1;
    if (x10_mode && (!pad || line_byte + 2 < line_len)) nbytes = 2;
    for (int b = 0; b < nbytes; b++) begin
      for (int i = 0; i < ByteBits; i++) begin
        // bits past the line width are dropped
        if (pix_col < img_width) begin
          p.index = word[ByteBits*b + i] ? fg_index : bg_index;
          p.last  = 1'b0;
          p.eoi   = (pix_col + 1 == img_width) && (rows_done + 1 == img_height);
          run.push_back(p);
          pix_col++;
        end
      end
    end
    line_byte += x10_mode ? 2 : 1;
    if (line_byte >= line_len) begin
      line_byte = 0;
      pix_col   = 0;
      rows_done++;
    end
    foreach (run[k]) begin
      p      = run[k];
      p.last = (k == run.size() - 1);
      pixels_due.push_back(p);
    end
  endfunction

  // Sender: one word on the bus at a time, random gaps between words
  always @(posedge clk_i or negedge rst_ni) begin
    logic                nxt_valid;
    logic [WordBits-1:0] nxt_word;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_word  = data_word_i;
      if (in_valid_i && !in_stall_o) begin
        predict_pixels(data_word_i);
        words_pending--;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (words_to_send.size() > 0) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 19);
          end else begin
            nxt_word  = words_to_send.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
      in_valid_i  <= nxt_valid;
      data_word_i <= nxt_word;
    end
  end

  // Receiver: check each taken pixel against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pixel: expected none, got index %0d last %0b eoi %0b",
                   $time, pixel_index_o, last_of_run_o, end_of_image_o);
        end else begin
          want = pixels_due.pop_front();
          if (pixel_index_o !== want.index) begin
            fail_count++;
            $display("%0t: pixel_index expected %0d got %0d",
                     $time, want.index, pixel_index_o);
          end
          if (last_of_run_o !== want.last) begin
            fail_count++;
            $display("%0t: last_of_run expected %0b got %0b",
                     $time, want.last, last_of_run_o);
          end
          if (end_of_image_o !== want.eoi) begin
            fail_count++;
            $display("%0t: end_of_image expected %0b got %0b",
                     $time, want.eoi, end_of_image_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("xbm_raster_bit_unpacker_tb NOT OK");
      $finish;
    end
  end

  function automatic void send(logic [WordBits-1:0] word);
    words_to_send.push_back(word);
    words_pending++;
    words_sent++;
  endfunction

  // Wait until every word is taken and every pixel seen, then let the
  // pipeline empty (a word with no pixels still passes through it).
  task automatic settle();
    do @(posedge clk_i); while (words_pending != 0 || pixels_due.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgWidth:      img_width  = value & DimMax;
      CfgHeight:     img_height = value & DimMax;
      CfgX10:        x10_mode   = value[0];
      CfgForeground: fg_index   = value[IndexBits-1:0];
      CfgBackground: bg_index   = value[IndexBits-1:0];
      default: ;
    endcase
  endtask

  initial begin
    int nwords;
    int h;
    int w;
    int c;
    bit split;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // Reset setup: 8 wide, 1 line, X11. High byte is ignored in X11.
    send(16'hFFA5);
    send(16'h00FF);  // image already finished: no pixels
    settle();

    write_reg(CfgForeground, 255);
    write_reg(CfgBackground, 0);
    write_reg(CfgWidth, 5);
    write_reg(CfgHeight, rows_done + 20);
    send(16'h0000);
    send(16'hFFFF);
    settle();

    // X10, no padding: one word per 13-pixel line
    write_reg(CfgX10, 1);
    write_reg(CfgWidth, 13);
    send(16'hFFFF);
    send(16'h5A5A);
    settle();
    write_reg(CfgWidth, 16);
    send(16'h8001);
    settle();
    // padded lines: high byte of the last word is skipped (width 9 is not padded)
    write_reg(CfgWidth, 4);
    send(16'hFF0F);
    settle();
    write_reg(CfgWidth, 24);
    send(16'hC3A5);
    send(16'h7E81);
    settle();
    write_reg(CfgWidth, 9);
    send(16'h01FF);
    settle();

    // zero width: lines end with no pixels, per word in X10, per byte in X11
    write_reg(CfgWidth, 0);
    send(16'hFFFF);
    settle();
    write_reg(CfgX10, 0);
    send(16'h00FF);
    settle();

    // widest line, left part way; then narrowed mid-line
    write_reg(CfgWidth, DimMax);
    send(16'h0001);
    send(16'h0080);
    send(16'h00AA);
    settle();
    write_reg(CfgWidth, 3);
    send(16'h00FF);  // column already past width: line just closes
    send(16'h0005);
    settle();

    // zero height: nothing comes out
    write_reg(CfgHeight, 0);
    send(16'hFFFF);
    settle();
    write_reg(CfgHeight, rows_done + 1);
    write_reg(CfgWidth, 10);
    write_reg(CfgX10, 1);
    send(16'h0355);  // last line of the image
    send(16'hFFFF);  // past the end
    settle();

    // ---- random part ----
    while (words_sent < 480) begin
      if (words_sent >= 400) calm = 1'b1;
      c = $urandom_range(0, 9);
      if (c == 0)      w = 0;
      else if (c == 1) w = $urandom_range(1, DimMax);
      else if (c == 2) w = DimMax;
      else             w = $urandom_range(1, 40);
      write_reg(CfgWidth, w);
      if ($urandom_range(0, 1) == 1) write_reg(CfgX10, $urandom_range(0, 1));
      c = $urandom_range(0, 3);
      write_reg(CfgForeground, c == 0 ? 0 : c == 1 ? 255 : $urandom_range(0, 255));
      c = $urandom_range(0, 3);
      write_reg(CfgBackground, c == 0 ? 0 : c == 1 ? 255 : $urandom_range(0, 255));
      c = $urandom_range(0, 9);
      if (c == 0)      h = DimMax;
      else if (c <= 2) h = rows_done + $urandom_range(0, 2);  // ends early
      else             h = rows_done + $urandom_range(2, 40);
      if (h > DimMax) h = DimMax;
      write_reg(CfgHeight, h);

      nwords = $urandom_range(8, 40);
      split  = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < nwords; k++) begin
        // hold the sender until the block has emptied
        if (split && k == nwords / 2) settle();
        send(WordBits'($urandom_range(0, 16'hFFFF)));
      end
      settle();
    end

    if (pixels_due.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected pixels never came", $time, pixels_due.size());
    end
    if (fail_count == 0) begin
      $display("xbm_raster_bit_unpacker_tb OK");
    end else begin
      $display("xbm_raster_bit_unpacker_tb NOT OK");
    end
    $finish;
  end

endmodule
